@@ rtl/cfir_pkg.sv @@
// Package for the complex direct form I IIR filter: widths, register indexes,
// sequencer types and the microcode table.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cfir_pkg;

  // Sample and packed complex widths
  localparam int SAMPLE_W = 16;
  localparam int CPLX_W   = 2 * SAMPLE_W;
  localparam int REG_W    = 32;
  localparam int REG_IDX_W = 3;

  // Parameter defaults for the top level
  localparam int DEF_FEEDFORWARD_TAPS = 3;
  localparam int DEF_FEEDBACK_TAPS    = 3;
  localparam int DEF_FRAC_BITS        = 15;

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_e;

  // Multiplier operand source
  typedef enum logic [2:0] {
    OPND_X,
    OPND_X1,
    OPND_X2,
    OPND_Y1,
    OPND_Y2
  } opnd_e;

  // Accumulator operation
  typedef enum logic [1:0] {
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  // Branch / end conditions
  typedef enum logic [1:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_FF_SHORT,
    COND_FB_SHORT
  } cond_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN,
    ST_WAIT
  } seq_state_e;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  // One control word per step
  typedef struct packed {
    opnd_e    opnd;
    cfg_reg_e coef;
    acc_op_e  op;
    cond_e    jmp_cond;
    step_t    jmp_tgt;
    cond_e    end_cond;
  } ucode_t;

  // Microcode: one complex MAC per step. A short feedforward section skips the
  // x2 tap; a short feedback section ends after the y1 tap.
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    unique case (s)
      3'd0:    w = '{OPND_X,  REG_B0, ACC_LOAD, COND_NEVER,    3'd0, COND_NEVER};
      3'd1:    w = '{OPND_X1, REG_B1, ACC_ADD,  COND_FF_SHORT, 3'd3, COND_NEVER};
      3'd2:    w = '{OPND_X2, REG_B2, ACC_ADD,  COND_NEVER,    3'd0, COND_NEVER};
      3'd3:    w = '{OPND_Y1, REG_A1, ACC_SUB,  COND_NEVER,    3'd0, COND_FB_SHORT};
      3'd4:    w = '{OPND_Y2, REG_A2, ACC_SUB,  COND_NEVER,    3'd0, COND_ALWAYS};
      default: w = '{OPND_X,  REG_B0, ACC_LOAD, COND_NEVER,    3'd0, COND_ALWAYS};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/cfir_cmul.sv @@
// Shared complex multiplier: four real products truncated to Q format,
// combined and registered. Depends on cfir_pkg.
`timescale 1ns / 1ps

module cfir_cmul
  import cfir_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic              clk_i,
  input  logic [CPLX_W-1:0] a_i,     // real [15:0], imag [31:16]
  input  logic [CPLX_W-1:0] b_i,     // real [15:0], imag [31:16]
  output logic [CPLX_W-1:0] prod_o   // real [15:0], imag [31:16]
);

  logic signed [2*SAMPLE_W-1:0] p_rr, p_ii, p_ri, p_ir;
  logic [SAMPLE_W-1:0] t_rr, t_ii, t_ri, t_ir;
  logic [CPLX_W-1:0]   prod_d, prod_q;

  // Full products
  assign p_rr = $signed(a_i[SAMPLE_W-1:0])      * $signed(b_i[SAMPLE_W-1:0]);
  assign p_ii = $signed(a_i[CPLX_W-1:SAMPLE_W]) * $signed(b_i[CPLX_W-1:SAMPLE_W]);
  assign p_ri = $signed(a_i[SAMPLE_W-1:0])      * $signed(b_i[CPLX_W-1:SAMPLE_W]);
  assign p_ir = $signed(a_i[CPLX_W-1:SAMPLE_W]) * $signed(b_i[SAMPLE_W-1:0]);

  // Floor truncation is an arithmetic shift; keep 16 bits (wraps)
  assign t_rr = p_rr[FRAC_BITS +: SAMPLE_W];
  assign t_ii = p_ii[FRAC_BITS +: SAMPLE_W];
  assign t_ri = p_ri[FRAC_BITS +: SAMPLE_W];
  assign t_ir = p_ir[FRAC_BITS +: SAMPLE_W];

  assign prod_d = {SAMPLE_W'(t_ri + t_ir), SAMPLE_W'(t_rr - t_ii)};

  // Product register
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/complex_fixed_iir_filter_unit.sv @@
// Complex direct form I IIR filter, Q1.15, microcoded over one shared complex MAC.
// The sequencer runs STEPS = FEEDFORWARD_TAPS + FEEDBACK_TAPS - 1 microcode steps per
// sample (5 by default). Only one sample is in work at a time: an accept cycle, one tap
// per cycle on the shared multiplier, then a product stage; y feedback closes the loop.
// A stalled output holds the sequencer in WAIT until the result can be written.
// Reset (async, active low): coefficients, histories and output valid cleared; output data is not reset.
`timescale 1ns / 1ps

module complex_fixed_iir_filter_unit
  import cfir_pkg::*;
#(
  parameter int FEEDFORWARD_TAPS = DEF_FEEDFORWARD_TAPS,
  parameter int FEEDBACK_TAPS    = DEF_FEEDBACK_TAPS,
  parameter int FRAC_BITS        = DEF_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Sample input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [CPLX_W-1:0]    s_axis_tdata,   // sample_re [15:0], sample_im [31:16]
  // Filtered output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [CPLX_W-1:0]    m_axis_tdata,   // filtered_re [15:0], filtered_im [31:16]
  // Coefficient write port
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_addr_i,
  input  logic [REG_W-1:0]     cfg_wdata_i
);

  localparam bit FfShort = (FEEDFORWARD_TAPS < 3);
  localparam bit FbShort = (FEEDBACK_TAPS < 3);

  function automatic logic cond_true(cond_e c);
    logic r;
    unique case (c)
      COND_NEVER:    r = 1'b0;
      COND_ALWAYS:   r = 1'b1;
      COND_FF_SHORT: r = FfShort;
      COND_FB_SHORT: r = FbShort;
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

  seq_state_e state_q, state_d;
  step_t      step_q, step_d;
  ucode_t     uw;

  logic [REG_W-1:0]  coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;
  logic [CPLX_W-1:0] x_q, x1_q, x2_q, y1_q, y2_q;
  logic [CPLX_W-1:0] opnd, coef, prod;
  logic [CPLX_W-1:0] acc_q, acc_next, result;
  acc_op_e           op_q;
  logic              ctl_vld_q;
  logic              issue, accept, out_free, out_wr;
  logic              m_valid_q;
  logic [CPLX_W-1:0] m_data_q;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign uw       = ucode_rom(step_q);

  // Coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b0_q <= '0;
      coef_b1_q <= '0;
      coef_b2_q <= '0;
      coef_a1_q <= '0;
      coef_a2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_B0:  coef_b0_q <= cfg_wdata_i;
        REG_B1:  coef_b1_q <= cfg_wdata_i;
        REG_B2:  coef_b2_q <= cfg_wdata_i;
        REG_A1:  coef_a1_q <= cfg_wdata_i;
        REG_A2:  coef_a2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer: next state, step counter, issue and output write
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    issue   = 1'b0;
    out_wr  = 1'b0;
    s_axis_tready = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (cond_true(uw.end_cond)) begin
          state_d = ST_FIN;
        end else if (cond_true(uw.jmp_cond)) begin
          step_d = uw.jmp_tgt;
        end else begin
          step_d = STEP_W'(step_q + 1'b1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_wr  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_wr  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      ctl_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      ctl_vld_q <= issue;
    end
  end

  // Operand and coefficient selection for the current step
  always_comb begin
    unique case (uw.opnd)
      OPND_X:  opnd = x_q;
      OPND_X1: opnd = x1_q;
      OPND_X2: opnd = x2_q;
      OPND_Y1: opnd = y1_q;
      OPND_Y2: opnd = y2_q;
      default: opnd = x_q;
    endcase
    unique case (uw.coef)
      REG_B0:  coef = coef_b0_q;
      REG_B1:  coef = coef_b1_q;
      REG_B2:  coef = coef_b2_q;
      REG_A1:  coef = coef_a1_q;
      REG_A2:  coef = coef_a2_q;
      default: coef = coef_b0_q;
    endcase
  end

  cfir_cmul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cmul (
    .clk_i (clk_i),
    .a_i   (opnd),
    .b_i   (coef),
    .prod_o(prod)
  );

  // Accumulator, wraps per 16-bit half
  always_comb begin
    unique case (op_q)
      ACC_LOAD: acc_next = prod;
      ACC_ADD:  acc_next = {SAMPLE_W'(acc_q[CPLX_W-1:SAMPLE_W] + prod[CPLX_W-1:SAMPLE_W]),
                            SAMPLE_W'(acc_q[SAMPLE_W-1:0] + prod[SAMPLE_W-1:0])};
      ACC_SUB:  acc_next = {SAMPLE_W'(acc_q[CPLX_W-1:SAMPLE_W] - prod[CPLX_W-1:SAMPLE_W]),
                            SAMPLE_W'(acc_q[SAMPLE_W-1:0] - prod[SAMPLE_W-1:0])};
      default:  acc_next = prod;
    endcase
  end

  // Final product lands in FIN; in WAIT the sum already sits in acc_q
  assign result = (state_q == ST_FIN) ? acc_next : acc_q;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      op_q <= uw.op;
    end
    if (ctl_vld_q) begin
      acc_q <= acc_next;
    end
    if (accept) begin
      x_q <= s_axis_tdata;
    end
  end

  // Histories shift when the result is committed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (out_wr) begin
      x1_q <= x_q;
      y1_q <= result;
      if (!FfShort) begin
        x2_q <= x1_q;
      end
      if (!FbShort) begin
        y2_q <= y1_q;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_wr) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_wr) begin
      m_data_q <= result;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

@@ rtl/cfir_checker.sv @@
// Port-level checks for complex_fixed_iir_filter_unit, attached by bind.
// Depends on cfir_pkg.
`timescale 1ns / 1ps

module cfir_checker
  import cfir_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [CPLX_W-1:0] m_axis_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output request changed while stalled");

  // One sample in flight: busy right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a sample is in work");

  // No result can show up while the first taps are still being run
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid ##1 !m_axis_tvalid)
    else $error("result appeared too early");

  // Writing a result frees the input side
  a_ready_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("input not ready after result write");

endmodule

bind complex_fixed_iir_filter_unit cfir_checker u_cfir_checker (.*);
